/* rtl/pbpm_pkg.sv */
package pbpm_pkg;

   localparam int ENTRIES_DEF    = 256;
   localparam int POOL_DEPTH_DEF = 256;
   localparam int MAX_BATCH_DEF  = 32;

   localparam int PKTID_W = 16;
   localparam int COUNT_W = 9;
   localparam int DATA_W  = 32;

   localparam logic [2:0] REQ_ALLOC       = 3'd0;
   localparam logic [2:0] REQ_RECLAIM     = 3'd1;
   localparam logic [2:0] REQ_REFILL      = 3'd2;
   localparam logic [2:0] REQ_SET_OWNER   = 3'd3;
   localparam logic [2:0] REQ_CHECK_OWNER = 3'd4;
   localparam logic [2:0] REQ_SYNC        = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NODEV = 2'd1;
   localparam logic [1:0] ST_INVAL = 2'd2;
   localparam logic [1:0] ST_NOMEM = 2'd3;

   localparam logic [1:0] OWNER_SW = 2'd0;
   localparam logic [1:0] OWNER_FW = 2'd1;

   localparam logic [1:0] CSR_ENABLED     = 2'd0;
   localparam logic [1:0] CSR_PKTID_OFFSET = 2'd1;
   localparam logic [1:0] CSR_ENTRY_COUNT = 2'd2;

endpackage

/* rtl/packet_buffer_pool_manager.sv */
// Packet buffer pool manager: a free-index stack, a refill bitmap and a
// two-bit owner code per entry, all held in single-port-read RAMs.
// Requests arrive on the req_ stream, one item per request. Each request
// returns one result item on the rsp_ stream with rsp_tlast set, except
// an allocate that grants buffers, which returns one item per buffer, the
// final one marked by rsp_tlast. Registers are to be written on the csr_
// port only while idle; the block does not enforce this. A request is
// taken in the idle state only. Check owner passes through a check
// state, allocate reads the stack and then emits for each buffer, and
// sync reads and checks the refill bit of each active entry in turn.
// A result sits in an output register; while the receiver stalls, the
// block holds at the next result and takes no new request.
// After reset the block clears the owner and refill RAMs, one entry a
// cycle; req_tready stays low during that pass, while register writes are
// taken as usual. Only state, clr_ff, top_ff, out_valid_ff and CSRs reset.
module packet_buffer_pool_manager #(
   parameter int ENTRIES    = pbpm_pkg::ENTRIES_DEF,
   parameter int POOL_DEPTH = pbpm_pkg::POOL_DEPTH_DEF,
   parameter int MAX_BATCH  = pbpm_pkg::MAX_BATCH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_type[2:0], pktid[18:3], alloc_count[24:19], owner_code[26:25],
   // sync_requested[27], zero fill above
   input  logic [pbpm_pkg::DATA_W-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], granted_pktid[17:2], owner_match[18], sync_count[27:19],
   // more_pending[28], zero fill above
   output logic [pbpm_pkg::DATA_W-1:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wr_data
);
   import pbpm_pkg::*;

   localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SW = $clog2(POOL_DEPTH);
   localparam int TW = $clog2(POOL_DEPTH + 1);
   localparam int IW = $clog2(ENTRIES + 1);
   localparam int BW = $clog2(MAX_BATCH + 1);
   localparam int LW = (IW > COUNT_W) ? IW : COUNT_W;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ALLOC_RD, S_ALLOC_OUT, S_CHECK,
      S_SYNC_RD, S_SYNC_CHK, S_EMIT
   } state_type;

   state_type               state_ff;
   logic [EW-1:0]           clr_ff;
   logic [TW-1:0]           top_ff;
   logic [BW-1:0]           remain_ff;
   logic [IW-1:0]           scan_ff;
   logic [1:0]              owner_ff;
   logic [1:0]              res_status_ff;
   logic                    res_match_ff;
   logic [COUNT_W-1:0]      res_cnt_ff;
   logic                    res_more_ff;
   logic                    out_valid_ff;
   logic [DATA_W-1:0]       out_data_ff;
   logic                    out_last_ff;
   logic                    enabled_ff;
   logic [PKTID_W-1:0]      offset_ff;
   logic [COUNT_W-1:0]      count_ff;

   logic [2:0]              f_type;
   logic [PKTID_W-1:0]      f_pktid;
   logic [5:0]              f_alloc;
   logic [1:0]              f_owner;
   logic                    f_sync;
   logic                    accept;
   logic                    slot_free;
   logic                    stack_full;
   logic [PKTID_W-1:0]      diff;
   logic [LW-1:0]           count_ext;
   logic [LW-1:0]           lim;
   logic                    idx_ok;
   logic [EW-1:0]           idx;
   logic [BW-1:0]           want;
   logic [TW-1:0]           top_m1;
   logic                    scan_in_range;
   logic                    sync_push;
   logic [PKTID_W-1:0]      granted;
   logic                    alloc_last;

   logic                    own_wr_en;
   logic [EW-1:0]           own_wr_addr;
   logic [1:0]              own_wr_data;
   logic [1:0]              own_rd_data;
   logic                    ref_wr_en;
   logic [EW-1:0]           ref_wr_addr;
   logic                    ref_wr_data;
   logic                    ref_rd_en;
   logic [0:0]              ref_rd_data;
   logic                    stk_wr_en;
   logic [SW-1:0]           stk_wr_addr;
   logic [EW-1:0]           stk_wr_data;
   logic                    stk_rd_en;
   logic [EW-1:0]           stk_rd_data;

   assign f_type  = req_tdata[2:0];
   assign f_pktid = req_tdata[18:3];
   assign f_alloc = req_tdata[24:19];
   assign f_owner = req_tdata[26:25];
   assign f_sync  = req_tdata[27];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !out_valid_ff || rsp_tready;
   assign stack_full = (top_ff == TW'(POOL_DEPTH));
   assign top_m1     = top_ff - TW'(1);

   assign diff      = f_pktid - offset_ff;
   assign count_ext = LW'(count_ff);
   assign lim       = (count_ext < LW'(ENTRIES)) ? count_ext : LW'(ENTRIES);
   assign idx_ok    = diff < PKTID_W'(lim);
   assign idx       = diff[EW-1:0];

   assign want = ({1'b0, f_alloc} > 7'(MAX_BATCH)) ? BW'(MAX_BATCH) : BW'(f_alloc);

   assign scan_in_range = LW'(scan_ff) < lim;
   assign sync_push     = (state_ff == S_SYNC_CHK) && ref_rd_data[0] && !stack_full;
   assign granted       = PKTID_W'(stk_rd_data) + offset_ff;
   assign alloc_last    = (remain_ff == '0) || (top_ff == '0);

   // Memory port steering. Each request touches an entry at most once, so no
   // two accesses to one entry are in flight together.
   always_comb begin
      own_wr_en   = 1'b0;
      own_wr_addr = idx;
      own_wr_data = OWNER_FW;
      ref_wr_en   = 1'b0;
      ref_wr_addr = idx;
      ref_wr_data = 1'b1;
      stk_wr_en   = 1'b0;
      stk_wr_addr = top_ff[SW-1:0];
      stk_wr_data = idx;
      if (state_ff == S_CLEAR) begin
         own_wr_en   = 1'b1;
         own_wr_addr = clr_ff;
         own_wr_data = OWNER_SW;
         ref_wr_en   = 1'b1;
         ref_wr_addr = clr_ff;
         ref_wr_data = 1'b0;
      end else if (accept && enabled_ff && idx_ok) begin
         case (f_type)
            REQ_RECLAIM: begin
               own_wr_en = 1'b1;
               stk_wr_en = !stack_full;
            end
            REQ_REFILL: begin
               ref_wr_en = 1'b1;
            end
            REQ_SET_OWNER: begin
               own_wr_en   = 1'b1;
               own_wr_data = f_owner;
            end
            default: begin
            end
         endcase
      end else if (sync_push) begin
         own_wr_en   = 1'b1;
         own_wr_addr = scan_ff[EW-1:0];
         ref_wr_en   = 1'b1;
         ref_wr_addr = scan_ff[EW-1:0];
         ref_wr_data = 1'b0;
         stk_wr_en   = 1'b1;
         stk_wr_data = scan_ff[EW-1:0];
      end
   end

   assign ref_rd_en = (state_ff == S_SYNC_RD) && scan_in_range;
   assign stk_rd_en = (state_ff == S_ALLOC_RD);

   pbpm_ram #(.WIDTH(2), .DEPTH(ENTRIES)) u_owner_ram (
      .clock   (clock),
      .wr_en   (own_wr_en),
      .wr_addr (own_wr_addr),
      .wr_data (own_wr_data),
      .rd_en   (accept),
      .rd_addr (idx),
      .rd_data (own_rd_data)
   );

   pbpm_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_refill_ram (
      .clock   (clock),
      .wr_en   (ref_wr_en),
      .wr_addr (ref_wr_addr),
      .wr_data (ref_wr_data),
      .rd_en   (ref_rd_en),
      .rd_addr (scan_ff[EW-1:0]),
      .rd_data (ref_rd_data)
   );

   pbpm_ram #(.WIDTH(EW), .DEPTH(POOL_DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (top_m1[SW-1:0]),
      .rd_data (stk_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         top_ff       <= '0;
         out_valid_ff <= 1'b0;
         enabled_ff   <= 1'b0;
         offset_ff    <= '0;
         count_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ENABLED:      enabled_ff <= csr_wr_data[0];
               CSR_PKTID_OFFSET: offset_ff  <= csr_wr_data;
               CSR_ENTRY_COUNT:  count_ff   <= csr_wr_data[COUNT_W-1:0];
               default: begin
               end
            endcase
         end
         if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + EW'(1);
               if (clr_ff == EW'(ENTRIES - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  res_status_ff <= ST_OK;
                  res_match_ff  <= 1'b0;
                  res_cnt_ff    <= '0;
                  res_more_ff   <= 1'b0;
                  owner_ff      <= f_owner;
                  state_ff      <= S_EMIT;
                  if (f_type > REQ_SYNC) begin
                     res_status_ff <= ST_INVAL;
                  end else if (!enabled_ff) begin
                     res_status_ff <= ST_NODEV;
                  end else if (f_type == REQ_ALLOC) begin
                     if (f_alloc == '0) begin
                        res_status_ff <= ST_INVAL;
                     end else if (top_ff == '0) begin
                        res_status_ff <= ST_NOMEM;
                     end else begin
                        remain_ff <= want;
                        state_ff  <= S_ALLOC_RD;
                     end
                  end else if (f_type == REQ_SYNC) begin
                     scan_ff <= '0;
                     if (f_sync) begin
                        state_ff <= S_SYNC_RD;
                     end
                  end else if (!idx_ok) begin
                     res_status_ff <= ST_INVAL;
                  end else if (f_type == REQ_CHECK_OWNER) begin
                     state_ff <= S_CHECK;
                  end else if (f_type == REQ_RECLAIM && !stack_full) begin
                     top_ff <= top_ff + TW'(1);
                  end
               end
            end
            S_ALLOC_RD: begin
               top_ff    <= top_m1;
               remain_ff <= remain_ff - BW'(1);
               state_ff  <= S_ALLOC_OUT;
            end
            S_ALLOC_OUT: begin
               if (slot_free) begin
                  out_valid_ff <= 1'b1;
                  out_data_ff  <= {3'b000, 1'b0, 9'd0, 1'b0, granted, ST_OK};
                  out_last_ff  <= alloc_last;
                  state_ff     <= alloc_last ? S_IDLE : S_ALLOC_RD;
               end
            end
            S_CHECK: begin
               res_match_ff <= (own_rd_data == owner_ff);
               state_ff     <= S_EMIT;
            end
            S_SYNC_RD: begin
               state_ff <= scan_in_range ? S_SYNC_CHK : S_EMIT;
            end
            S_SYNC_CHK: begin
               if (ref_rd_data[0] && stack_full) begin
                  res_more_ff <= 1'b1;
                  state_ff    <= S_EMIT;
               end else begin
                  if (sync_push) begin
                     top_ff     <= top_ff + TW'(1);
                     res_cnt_ff <= res_cnt_ff + COUNT_W'(1);
                  end
                  scan_ff  <= scan_ff + IW'(1);
                  state_ff <= S_SYNC_RD;
               end
            end
            S_EMIT: begin
               if (slot_free) begin
                  out_valid_ff <= 1'b1;
                  out_data_ff  <= {3'b000, res_more_ff, res_cnt_ff, res_match_ff,
                                   16'd0, res_status_ff};
                  out_last_ff  <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= TW'(POOL_DEPTH))
      else $error("free stack pointer beyond pool depth");

   a_pop_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ALLOC_RD |=> top_ff == $past(top_ff) - TW'(1))
      else $error("allocate pop did not lower the stack pointer by one");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ALLOC_RD |-> top_ff != '0)
      else $error("pop from an empty free stack");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SYNC_CHK |-> LW'(scan_ff) < lim)
      else $error("sync scan beyond active entries");
`endif
endmodule

/* rtl/pbpm_ram.sv */
module pbpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
